// ----- hw/rtl/rsk_pkg.sv -----
// Package for the record sorter: field widths, key select codes and the record type.
// Used by the channel interfaces, the key unit and the top level.
package rsk_pkg;

    localparam int STAT_W          = 16;
    localparam int KEY_W           = 19;
    localparam int SEL_W           = 3;
    localparam int MAX_RECORDS_DEF = 64;

    // Key select codes; any other code selects the sum of all six stats.
    localparam logic [SEL_W-1:0] KEY_AGE       = 3'd2;
    localparam logic [SEL_W-1:0] KEY_ATTACK    = 3'd3;
    localparam logic [SEL_W-1:0] KEY_DEFENSE   = 3'd4;
    localparam logic [SEL_W-1:0] KEY_SPEED     = 3'd5;
    localparam logic [SEL_W-1:0] KEY_HEALTH    = 3'd6;
    localparam logic [SEL_W-1:0] KEY_SEL_RESET = 3'd1;

    // One stored record.
    typedef struct packed {
        logic [STAT_W-1:0] tag;
        logic [STAT_W-1:0] speed;
        logic [STAT_W-1:0] health;
        logic [STAT_W-1:0] defense;
        logic [STAT_W-1:0] attack;
        logic [STAT_W-1:0] age;
        logic [STAT_W-1:0] level;
    } rec_t;

endpackage

// ----- hw/rtl/rsk_in_if.sv -----
// Input record channel with valid/ready handshake.
// Depends on rsk_pkg for the field widths.
interface rsk_in_if;
    logic                       valid;
    logic                       ready;
    logic [rsk_pkg::STAT_W-1:0] level;
    logic [rsk_pkg::STAT_W-1:0] age;
    logic [rsk_pkg::STAT_W-1:0] attack;
    logic [rsk_pkg::STAT_W-1:0] defense;
    logic [rsk_pkg::STAT_W-1:0] health;
    logic [rsk_pkg::STAT_W-1:0] speed;
    logic [rsk_pkg::STAT_W-1:0] tag;
    logic                       in_last;

    modport source (
        output valid, level, age, attack, defense, health, speed, tag, in_last,
        input  ready
    );
    modport sink (
        input  valid, level, age, attack, defense, health, speed, tag, in_last,
        output ready
    );
endinterface

// ----- hw/rtl/rsk_out_if.sv -----
// Sorted record output channel with valid/ready handshake.
// Depends on rsk_pkg for the field widths.
interface rsk_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsk_pkg::STAT_W-1:0] out_level;
    logic [rsk_pkg::STAT_W-1:0] out_age;
    logic [rsk_pkg::STAT_W-1:0] out_attack;
    logic [rsk_pkg::STAT_W-1:0] out_defense;
    logic [rsk_pkg::STAT_W-1:0] out_health;
    logic [rsk_pkg::STAT_W-1:0] out_speed;
    logic [rsk_pkg::STAT_W-1:0] out_tag;
    logic                       out_last;

    modport source (
        output valid, out_level, out_age, out_attack, out_defense, out_health,
               out_speed, out_tag, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_level, out_age, out_attack, out_defense, out_health,
               out_speed, out_tag, out_last,
        output ready
    );
endinterface

// ----- hw/rtl/rsk_cfg_if.sv -----
// Configuration write channel carrying the key select register value.
// Depends on rsk_pkg for the register width.
interface rsk_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rsk_pkg::SEL_W-1:0] key_select;

    modport source (output valid, key_select, input ready);
    modport sink   (input valid, key_select, output ready);
endinterface

// ----- hw/rtl/rsk_key_unit.sv -----
// Shared key unit: forms the selected sort key of one record and registers it.
// Depends on rsk_pkg for the record type and key select codes.
module rsk_key_unit #(
    parameter int ADDR_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rsk_pkg::SEL_W-1:0]  key_select,
    input  logic                       rec_valid,
    input  logic [ADDR_W-1:0]          rec_idx,
    input  rsk_pkg::rec_t              rec,
    output logic                       key_valid,
    output logic [ADDR_W-1:0]          key_idx,
    output logic [rsk_pkg::KEY_W-1:0]  key
);

    logic [rsk_pkg::KEY_W-1:0] sum;
    logic [rsk_pkg::KEY_W-1:0] key_next;
    logic                      key_valid_reg;
    logic [ADDR_W-1:0]         key_idx_reg;
    logic [rsk_pkg::KEY_W-1:0] key_reg;

    // Lossless sum of all six stats.
    assign sum = rsk_pkg::KEY_W'(rec.level) + rsk_pkg::KEY_W'(rec.age)
               + rsk_pkg::KEY_W'(rec.attack) + rsk_pkg::KEY_W'(rec.defense)
               + rsk_pkg::KEY_W'(rec.health) + rsk_pkg::KEY_W'(rec.speed);

    // Pick the stat named by the key select register.
    always_comb
    begin
        case (key_select)
            rsk_pkg::KEY_AGE:     key_next = rsk_pkg::KEY_W'(rec.age);
            rsk_pkg::KEY_ATTACK:  key_next = rsk_pkg::KEY_W'(rec.attack);
            rsk_pkg::KEY_DEFENSE: key_next = rsk_pkg::KEY_W'(rec.defense);
            rsk_pkg::KEY_SPEED:   key_next = rsk_pkg::KEY_W'(rec.speed);
            rsk_pkg::KEY_HEALTH:  key_next = rsk_pkg::KEY_W'(rec.health);
            default:              key_next = sum;
        endcase
    end

    // The valid flag is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
        end
        else
        begin
            key_valid_reg <= rec_valid;
        end
    end

    // Key and index travel alongside without reset.
    always_ff @(posedge clk)
    begin
        key_idx_reg <= rec_idx;
        key_reg     <= key_next;
    end

    assign key_valid = key_valid_reg;
    assign key_idx   = key_idx_reg;
    assign key       = key_reg;

endmodule

// ----- hw/rtl/record_sort_by_selected_key.sv -----
// Top level of the record sorter: record store, scan sequencer and output register.
// Depends on rsk_pkg, the rsk_in_if, rsk_out_if and rsk_cfg_if interfaces and rsk_key_unit.
//
// Records are taken one per cycle until the request carrying in_last closes the batch;
// records beyond MAX_RECORDS are dropped. The batch of n records then comes out in
// descending key order, equal keys in arrival order. Each output record costs one full
// pass of the shared key unit and comparator over the store through its single read
// port, and a stalled output holds the batch back. The input is not ready from the closing
// request until the last sorted record is taken. key_select is sampled during the scan;
// write it between batches. No clearing pass is needed after reset.
module record_sort_by_selected_key #(
    parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rsk_in_if.sink     records,
    rsk_out_if.source  sorted,
    rsk_cfg_if.sink    cfg
);

    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {S_FILL, S_SCAN, S_FETCH, S_LOAD, S_EMIT} state_t;

    state_t                    state_reg;
    logic [rsk_pkg::SEL_W-1:0] key_sel_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          scan_cnt_reg;
    logic [CNT_W-1:0]          done_cnt_reg;
    logic                      p1_valid_reg;
    logic [ADDR_W-1:0]         p1_idx_reg;
    logic                      best_valid_reg;
    logic [ADDR_W-1:0]         best_idx_reg;
    logic [rsk_pkg::KEY_W-1:0] best_key_reg;
    logic [MAX_RECORDS-1:0]    taken_reg;
    rsk_pkg::rec_t             out_rec_reg;
    logic                      out_last_reg;

    rsk_pkg::rec_t             mem [MAX_RECORDS];
    rsk_pkg::rec_t             rd_data_reg;
    rsk_pkg::rec_t             wr_rec;

    logic                      accept_in;
    logic                      wr_en;
    logic                      issue;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      p2_valid;
    logic [ADDR_W-1:0]         p2_idx;
    logic [rsk_pkg::KEY_W-1:0] p2_key;
    logic                      cand;
    logic                      scan_done;

    // Handshake and store write control.
    assign records.ready = (state_reg == S_FILL);
    assign cfg.ready     = 1'b1;
    assign accept_in     = records.valid && records.ready;
    assign wr_en         = accept_in && (count_reg < CNT_W'(MAX_RECORDS));

    assign wr_rec.level   = records.level;
    assign wr_rec.age     = records.age;
    assign wr_rec.attack  = records.attack;
    assign wr_rec.defense = records.defense;
    assign wr_rec.health  = records.health;
    assign wr_rec.speed   = records.speed;
    assign wr_rec.tag     = records.tag;

    // The scan walks the store in order; a fetch reads the chosen record back.
    assign issue   = (state_reg == S_SCAN) && (scan_cnt_reg != count_reg);
    assign rd_addr = (state_reg == S_SCAN) ? scan_cnt_reg[ADDR_W-1:0] : best_idx_reg;

    // Record store with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_rec;
        end
        rd_data_reg <= mem[rd_addr];
    end

    rsk_key_unit #(
        .ADDR_W (ADDR_W)
    ) u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_select (key_sel_reg),
        .rec_valid  (p1_valid_reg),
        .rec_idx    (p1_idx_reg),
        .rec        (rd_data_reg),
        .key_valid  (p2_valid),
        .key_idx    (p2_idx),
        .key        (p2_key)
    );

    // Strictly greater keeps the earliest record among equal keys.
    assign cand = p2_valid && !taken_reg[p2_idx]
               && (!best_valid_reg || (p2_key > best_key_reg));
    assign scan_done = (state_reg == S_SCAN) && !issue && !p1_valid_reg && !p2_valid;

    // Sequencer, store bookkeeping and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            key_sel_reg    <= rsk_pkg::KEY_SEL_RESET;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            done_cnt_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            p1_idx_reg     <= '0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_key_reg   <= '0;
            taken_reg      <= '0;
            out_rec_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                key_sel_reg <= cfg.key_select;
            end

            p1_valid_reg <= issue;
            p1_idx_reg   <= scan_cnt_reg[ADDR_W-1:0];

            case (state_reg)
                S_FILL:
                begin
                    if (wr_en)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (accept_in && records.in_last)
                    begin
                        state_reg      <= S_SCAN;
                        scan_cnt_reg   <= '0;
                        done_cnt_reg   <= '0;
                        taken_reg      <= '0;
                        best_valid_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                    if (cand)
                    begin
                        best_valid_reg <= 1'b1;
                        best_idx_reg   <= p2_idx;
                        best_key_reg   <= p2_key;
                    end
                    if (scan_done)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    out_rec_reg  <= rd_data_reg;
                    out_last_reg <= ((done_cnt_reg + CNT_W'(1)) == count_reg);
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (sorted.ready)
                    begin
                        taken_reg[best_idx_reg] <= 1'b1;
                        done_cnt_reg            <= done_cnt_reg + CNT_W'(1);
                        best_valid_reg          <= 1'b0;
                        scan_cnt_reg            <= '0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_FILL;
                            count_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

    // Output channel.
    assign sorted.valid       = (state_reg == S_EMIT);
    assign sorted.out_level   = out_rec_reg.level;
    assign sorted.out_age     = out_rec_reg.age;
    assign sorted.out_attack  = out_rec_reg.attack;
    assign sorted.out_defense = out_rec_reg.defense;
    assign sorted.out_health  = out_rec_reg.health;
    assign sorted.out_speed   = out_rec_reg.speed;
    assign sorted.out_tag     = out_rec_reg.tag;
    assign sorted.out_last    = out_last_reg;

`ifndef SYNTH
    // The store never holds more records than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds store depth");

    // A record presented on the output has not been sent before in this batch.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !taken_reg[best_idx_reg])
        else $error("record emitted twice");

    // No more records are emitted than the batch holds.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (done_cnt_reg < count_reg))
        else $error("emitted more records than stored");

    // Taking the last record empties the store and reopens the input.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (sorted.valid && sorted.ready && out_last_reg)
        |=> (state_reg == S_FILL) && (count_reg == '0))
        else $error("batch did not close after last record");
`endif

endmodule
